>>> sv/bsf_pkg.sv
// Package for the block stream framer.
// Holds the item mode codes and the fixed framing words; no dependencies.
`default_nettype none

package bsf_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_HEADER  = 2'd0;
  localparam mode_t MODE_PAYLOAD = 2'd1;
  localparam mode_t MODE_END     = 2'd2;

  localparam logic [31:0] PAD_WORD     = 32'hFFFF_D9FF;
  localparam int unsigned END_FLAG_BIT = 27;

endpackage

`default_nettype wire

>>> sv/block_stream_framer.sv
// Block stream framer: header/payload pass-through, end flag insertion and
// frame padding. Depends on bsf_pkg for mode codes and framing words.
//
// A header or payload transaction is accepted and its result
// word goes to a one-entry output register; a new input transaction is
// taken in the same cycle that the previous result is taken. A frame-end
// transaction starts the pad sequencer, which emits ALIGN_WORDS - phase pad
// words (1 to ALIGN_WORDS), one per cycle while the output is not stalled;
// the input is stalled for that whole run. The pad run steps through the same
// wrapping phase incrementer that counts header and payload words, and the
// last pad word is the one that brings the phase back to zero. Misordered
// transactions give a single result with order_error set and a zero word.
`default_nettype none

module block_stream_framer
  import bsf_pkg::*;
#(
  parameter int ALIGN_WORDS       = 32,
  parameter int MAX_PAYLOAD_WORDS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_word_in,
  input  wire logic        in_last_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_word_out,
  output logic             out_frame_last,
  output logic             out_order_error
);

  localparam int PW = (ALIGN_WORDS > 1) ? $clog2(ALIGN_WORDS) : 1;
  localparam int LW = $clog2(MAX_PAYLOAD_WORDS + 1);
  localparam logic [PW-1:0] PHASE_LAST = PW'(ALIGN_WORDS - 1);
  localparam logic [8:0]    MAX_CNT    = 9'(MAX_PAYLOAD_WORDS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PAD  = 1'b1;

  logic          state_r, state_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic          seen_r, seen_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_word_r, out_word_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_err_r, out_err_nxt;

  logic          out_free;
  logic          in_acc;
  logic          phase_wrap;
  logic [PW-1:0] phase_inc;
  logic [8:0]    len_cnt;
  logic [LW-1:0] hdr_cnt;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r == ST_PAD) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Shared phase incrementer, wrapping at the alignment length.
  assign phase_wrap = (phase_r == PHASE_LAST);
  assign phase_inc  = phase_wrap ? '0 : phase_r + PW'(1);

  always_comb begin
    len_cnt = {1'b0, in_word_in[9:2]} + 9'd1;
    if (len_cnt > MAX_CNT) begin
      len_cnt = MAX_CNT;
    end
    hdr_cnt = LW'(len_cnt);
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    left_nxt      = left_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;

    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '0;
      out_last_nxt  = 1'b0;
      out_err_nxt   = 1'b1;
      case (in_mode)
        MODE_HEADER: begin
          if (left_r == '0) begin
            left_nxt     = hdr_cnt;
            seen_nxt     = 1'b1;
            phase_nxt    = phase_inc;
            out_word_nxt = in_word_in;
            out_word_nxt[END_FLAG_BIT] = in_word_in[END_FLAG_BIT] | in_last_block;
            out_err_nxt  = 1'b0;
          end
        end
        MODE_PAYLOAD: begin
          if (left_r != '0) begin
            left_nxt     = left_r - LW'(1);
            phase_nxt    = phase_inc;
            out_word_nxt = in_word_in;
            out_err_nxt  = 1'b0;
          end
        end
        MODE_END: begin
          if (left_r == '0) begin
            // An empty frame produces nothing; otherwise start the pad run.
            out_valid_nxt = 1'b0;
            out_err_nxt   = 1'b0;
            if (seen_r) begin
              state_nxt = ST_PAD;
              seen_nxt  = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (state_r == ST_PAD && out_free) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = PAD_WORD;
      out_last_nxt  = phase_wrap;
      out_err_nxt   = 1'b0;
      phase_nxt     = phase_inc;
      if (phase_wrap) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      left_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      left_r      <= left_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_word_out    = out_word_r;
  assign out_frame_last  = out_last_r;
  assign out_order_error = out_err_r;

  // An error result never carries a word.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_word_r == '0))
    else $error("order error result with nonzero word");

  // The final pad word closes the run and returns the phase to zero.
  a_pad_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAD && out_free && phase_wrap) |=>
      (state_r == ST_IDLE && phase_r == '0 && out_last_r))
    else $error("pad run did not close cleanly");

  // A pad run only happens once the block is complete and the frame is closed.
  a_pad_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAD) |-> (left_r == '0 && !seen_r))
    else $error("pad run with open block or frame");

  // The payload countdown never exceeds its saturation limit.
  a_left_max: assert property (@(posedge clk) disable iff (!rst_n)
    ({{(16-LW){1'b0}}, left_r} <= 16'(MAX_PAYLOAD_WORDS)))
    else $error("payload count above limit");

endmodule

`default_nettype wire
